// ===== hdl/shrgb_pkg.sv =====
// Package for the SH DC to RGB8 converter: widths, the quantised SH
// constant and the word type that travels down the divider stages.
// No dependencies.
`default_nettype none

package shrgb_pkg;

    localparam int COEF_W     = 16;
    // C0 = 0.28209479177387814 in units of 2^-24, with a sign bit for the multiply.
    localparam int CQ_W       = 24;
    localparam int CZERO_FRAC = 24;
    localparam logic signed [CQ_W-1:0] CZERO_Q = 24'sd4732765;
    // Channel value width: a 16 x 23 bit product plus the 0.5 offset stays
    // below 2^39 for every supported fraction width.
    localparam int VW     = 39;
    localparam int BYTE_W = 8;
    // Dividend is the channel times 255.
    localparam int NW     = VW + BYTE_W;
    localparam int NCH    = 3;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [VW-1:0]            t_chan;
    typedef logic [NW-1:0]            t_num;
    typedef logic [BYTE_W-1:0]        t_byte;

    typedef struct packed {
        t_num  [NCH-1:0] num;
        t_chan           den;
        t_byte [NCH-1:0] quo;
    } t_div_word;

endpackage

`default_nettype wire

// ===== hdl/shrgb_chan.sv =====
// One colour channel front end: multiply by the SH constant, then add 0.5
// and clamp at zero. Two register stages. Uses shrgb_pkg.
`default_nettype none

module shrgb_chan #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_ld_prod,
    input  wire logic            i_ld_val,
    input  wire shrgb_pkg::t_coef i_coef,
    output shrgb_pkg::t_chan     o_val
);

    localparam int PW = shrgb_pkg::COEF_W + shrgb_pkg::CQ_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF =
        SW'(1) <<< (FRAC_BITS + shrgb_pkg::CZERO_FRAC - 1);

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] n_prod;
    shrgb_pkg::t_chan     r_val;
    shrgb_pkg::t_chan     n_val;
    logic signed [SW-1:0] sum;

    assign n_prod = PW'(i_coef) * PW'(shrgb_pkg::CZERO_Q);

    always_comb begin
        sum = SW'(r_prod) + HALF;
        // Negative channels clamp to zero.
        if (sum[SW-1]) begin
            n_val = '0;
        end else begin
            n_val = sum[shrgb_pkg::VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_prod) begin
            r_prod <= n_prod;
        end
        if (i_ld_val) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// ===== hdl/shrgb_norm.sv =====
// Normalisation set-up: finds the largest channel, forms channel * 255 and
// picks the divisor (the largest channel, or 1.0). Two register stages.
// Uses shrgb_pkg.
`default_nettype none

module shrgb_norm #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_ld_max,
    input  wire logic                       i_ld_den,
    input  wire shrgb_pkg::t_chan [shrgb_pkg::NCH-1:0] i_val,
    output shrgb_pkg::t_div_word            o_word
);

    localparam shrgb_pkg::t_chan ONE =
        shrgb_pkg::t_chan'(1) << (FRAC_BITS + shrgb_pkg::CZERO_FRAC);

    shrgb_pkg::t_chan                      r_max;
    shrgb_pkg::t_chan                      n_max;
    shrgb_pkg::t_num [shrgb_pkg::NCH-1:0]  r_num;
    shrgb_pkg::t_num [shrgb_pkg::NCH-1:0]  n_num;
    shrgb_pkg::t_div_word                  r_word;
    shrgb_pkg::t_div_word                  n_word;
    shrgb_pkg::t_chan                      max_rg;

    always_comb begin
        max_rg = (i_val[1] > i_val[0]) ? i_val[1] : i_val[0];
        n_max  = (i_val[2] > max_rg) ? i_val[2] : max_rg;
        for (int c = 0; c < shrgb_pkg::NCH; c++) begin
            n_num[c] = (shrgb_pkg::t_num'(i_val[c]) << shrgb_pkg::BYTE_W)
                     - shrgb_pkg::t_num'(i_val[c]);
        end
    end

    // Dividing by 1.0 is the plain shift, so both cases share the divider.
    always_comb begin
        n_word.num = r_num;
        n_word.den = (r_max > ONE) ? r_max : ONE;
        n_word.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_max) begin
            r_max <= n_max;
            r_num <= n_num;
        end
        if (i_ld_den) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== hdl/shrgb_div_step.sv =====
// One restoring-division step: settles one quotient bit for all three
// channels and registers the partial remainders. Uses shrgb_pkg.
`default_nettype none

module shrgb_div_step #(
    parameter int BIT = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_ld,
    input  wire shrgb_pkg::t_div_word i_word,
    output shrgb_pkg::t_div_word      o_word
);

    shrgb_pkg::t_div_word r_word;
    shrgb_pkg::t_div_word n_word;
    shrgb_pkg::t_num      trial;
    logic                 ge;

    always_comb begin
        trial       = shrgb_pkg::t_num'(i_word.den) << BIT;
        n_word.den  = i_word.den;
        n_word.num  = i_word.num;
        n_word.quo  = i_word.quo;
        ge          = 1'b0;
        for (int c = 0; c < shrgb_pkg::NCH; c++) begin
            ge = (i_word.num[c] >= trial);
            if (ge) begin
                n_word.num[c] = i_word.num[c] - trial;
            end
            n_word.quo[c] = {i_word.quo[c][shrgb_pkg::BYTE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== hdl/sh_dc_to_rgb8_top.sv =====
// Converts a splat's three DC spherical-harmonic coefficients into an 8-bit
// RGB triple.
//
// Input channel: i_valid / o_ready with three signed 16-bit coefficients in
// fixed point with FRAC_BITS fraction bits. Output channel: o_valid / i_ready
// with three unsigned bytes. One result word for every input word, in order.
//
// The datapath is a 12-stage pipeline: constant multiply, offset and clamp,
// maximum search, divisor select, then eight restoring-division stages that
// each settle one bit of the bytes. One word per cycle is sustained while the
// receiver does not stall.
//
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves on, so bubbles close up while the receiver stalls and
// o_ready stays high until all twelve stages hold a word.
// Reset empties the pipeline; no results are pending afterwards.
// Depends on shrgb_pkg, shrgb_chan, shrgb_norm and shrgb_div_step.
`default_nettype none

module sh_dc_to_rgb8_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_coef_red,
    input  wire logic signed [15:0]  i_coef_green,
    input  wire logic signed [15:0]  i_coef_blue,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_red_byte,
    output logic [7:0]               o_green_byte,
    output logic [7:0]               o_blue_byte
);

    localparam int FRONT = 4;
    localparam int NST   = FRONT + shrgb_pkg::BYTE_W;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   n_vld;
    logic [NST:0]     adv;

    shrgb_pkg::t_coef [shrgb_pkg::NCH-1:0]  coef;
    shrgb_pkg::t_chan [shrgb_pkg::NCH-1:0]  val;
    shrgb_pkg::t_div_word [shrgb_pkg::BYTE_W:0] word;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        adv[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign n_vld = {r_vld[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign coef[0] = i_coef_red;
    assign coef[1] = i_coef_green;
    assign coef[2] = i_coef_blue;

    for (genvar c = 0; c < shrgb_pkg::NCH; c++) begin : g_chan
        shrgb_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .i_clk     (i_clk),
            .i_ld_prod (adv[0]),
            .i_ld_val  (adv[1]),
            .i_coef    (coef[c]),
            .o_val     (val[c])
        );
    end

    shrgb_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_ld_max (adv[2]),
        .i_ld_den (adv[3]),
        .i_val    (val),
        .o_word   (word[0])
    );

    for (genvar j = 0; j < shrgb_pkg::BYTE_W; j++) begin : g_div
        shrgb_div_step #(
            .BIT (shrgb_pkg::BYTE_W - 1 - j)
        ) u_step (
            .i_clk  (i_clk),
            .i_ld   (adv[FRONT+j]),
            .i_word (word[j]),
            .o_word (word[j+1])
        );
    end

    assign o_ready      = adv[0];
    assign o_valid      = r_vld[NST-1];
    assign o_red_byte   = word[shrgb_pkg::BYTE_W].quo[0];
    assign o_green_byte = word[shrgb_pkg::BYTE_W].quo[1];
    assign o_blue_byte  = word[shrgb_pkg::BYTE_W].quo[2];

endmodule

`default_nettype wire

// ===== hdl/shrgb_check.sv =====
// Port-level checker for sh_dc_to_rgb8_top, attached with a bind below.
// Tracks the number of words in flight. Depends on the top level's ports only.
`default_nettype none

module shrgb_check #(
    parameter int DEPTH = 12
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_red_byte,
    input wire logic [7:0] o_green_byte,
    input wire logic [7:0] o_blue_byte
);

    localparam int CW = $clog2(DEPTH + 2);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + CW'(1);
        end else if (out_acc && !in_acc) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A stalled result word holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_byte)
            && $stable(o_green_byte) && $stable(o_blue_byte))
        else $error("stalled result word changed");

    // An empty or draining output stage keeps o_ready high.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input blocked while the output is free");

    // No more words in flight than the pipeline has stages.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("more words in flight than pipeline stages");

    // A result is shown only for a word that was taken in.
    a_orig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result word without a pending input word");

    // Reset leaves nothing pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

endmodule

bind sh_dc_to_rgb8_top shrgb_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_red_byte   (o_red_byte),
    .o_green_byte (o_green_byte),
    .o_blue_byte  (o_blue_byte)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sh_dc_to_rgb8_top: drives coefficient words, predicts
// each RGB byte triple in exact integer arithmetic and checks every result word in order.
// Depends on shrgb_pkg and the RTL of the converter.

module tb;

    localparam int FRAC_BITS  = 12;
    localparam int SCALE_BITS = FRAC_BITS + shrgb_pkg::CZERO_FRAC;
    localparam int WATCHDOG   = 4000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 30;

    typedef struct packed {
        shrgb_pkg::t_byte red;
        shrgb_pkg::t_byte green;
        shrgb_pkg::t_byte blue;
    } t_rgb_word;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready = 1'b0;
    shrgb_pkg::t_coef i_coef_red = '0;
    shrgb_pkg::t_coef i_coef_green = '0;
    shrgb_pkg::t_coef i_coef_blue = '0;
    logic  o_ready;
    logic  o_valid;
    shrgb_pkg::t_byte o_red_byte;
    shrgb_pkg::t_byte o_green_byte;
    shrgb_pkg::t_byte o_blue_byte;

    t_rgb_word rgb_expected_q[$];
    int        words_sent = 0;
    int        words_checked = 0;
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    sh_dc_to_rgb8_top #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_coef_red   (i_coef_red),
        .i_coef_green (i_coef_green),
        .i_coef_blue  (i_coef_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_byte   (o_red_byte),
        .o_green_byte (o_green_byte),
        .o_blue_byte  (o_blue_byte)
    );

    always #1 i_clk = ~i_clk;

    // Each channel is 0.5 + C0 * coef held exactly in units of 2^-SCALE_BITS,
    // clamped at zero, then scaled by 255 over either 1.0 or the brightest channel.
    function automatic t_rgb_word predict_rgb(input shrgb_pkg::t_coef r,
                                              input shrgb_pkg::t_coef g,
                                              input shrgb_pkg::t_coef b);
        shrgb_pkg::t_coef  coef[3];
        longint            level;
        longint unsigned   chan[3];
        longint unsigned   peak;
        longint unsigned   unity;
        longint unsigned   quot;
        shrgb_pkg::t_byte  bytes[3];
        t_rgb_word         res;
        int                k;
        coef[0] = r;
        coef[1] = g;
        coef[2] = b;
        unity = 64'd1 << SCALE_BITS;
        for (k = 0; k < 3; k++) begin
            level = longint'(coef[k]) * longint'(shrgb_pkg::CZERO_Q)
                  + (longint'(1) << (SCALE_BITS - 1));
            chan[k] = (level < 0) ? 64'd0 : longint'(level);
        end
        peak = chan[0];
        if (chan[1] > peak) peak = chan[1];
        if (chan[2] > peak) peak = chan[2];
        for (k = 0; k < 3; k++) begin
            if (peak > unity)
                quot = (chan[k] * 255) / peak;
            else
                quot = (chan[k] * 255) >> SCALE_BITS;
            if (quot > 255) quot = 255;
            bytes[k] = quot[7:0];
        end
        res.red   = bytes[0];
        res.green = bytes[1];
        res.blue  = bytes[2];
        return res;
    endfunction

    // Weighted towards the band where channels neither clamp nor saturate,
    // and towards the coefficients where a channel crosses 0.0 or 1.0.
    function automatic shrgb_pkg::t_coef rand_coef();
        int unsigned sel;
        int          mag;
        sel = $urandom_range(99);
        mag = 7256 + int'($urandom_range(8));
        if (sel < 35)
            return shrgb_pkg::t_coef'($urandom);
        else if (sel < 75)
            return shrgb_pkg::t_coef'(int'($urandom_range(16000)) - 8000);
        else if (sel < 90)
            return shrgb_pkg::t_coef'($urandom_range(1) ? mag : -mag);
        else
            return shrgb_pkg::t_coef'(int'($urandom_range(64)) - 32);
    endfunction

    task automatic send_word(input shrgb_pkg::t_coef r, input shrgb_pkg::t_coef g,
                             input shrgb_pkg::t_coef b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_coef_red   <= r;
        i_coef_green <= g;
        i_coef_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (words_checked != words_sent) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(16'sd0, 16'sd0, 16'sd0);
        send_word(-16'sd32768, -16'sd32768, -16'sd32768);
        send_word(16'sd32767, 16'sd32767, 16'sd32767);
        send_word(16'sd32767, -16'sd32768, 16'sd0);
        send_word(-16'sd32768, 16'sd32767, 16'sd0);
        send_word(16'sd0, -16'sd32768, 16'sd32767);
        // Brightest channel just below, near and just above 1.0.
        send_word(16'sd7259, 16'sd0, -16'sd100);
        send_word(16'sd7260, 16'sd3000, -16'sd3000);
        send_word(16'sd7261, 16'sd3000, -16'sd3000);
        send_word(16'sd7260, 16'sd7260, 16'sd7260);
        send_word(16'sd7261, 16'sd7261, 16'sd7261);
        // Channels just above and below zero after the offset.
        send_word(-16'sd7259, -16'sd7260, -16'sd7261);
        send_word(-16'sd7261, -16'sd7261, -16'sd7261);
        send_word(-16'sd7259, -16'sd7259, -16'sd7259);
        send_word(16'sd1, -16'sd1, 16'sd0);
        send_word(16'sd14000, 16'sd7000, 16'sd0);
        send_word(-16'sd1, -16'sd1, -16'sd1);
        send_word(16'sd32767, 16'sd32766, 16'sd16384);
        send_word(16'sh5555, 16'shAAAA - 16'sd0, 16'sh7FFF);
        send_word(16'sh0F0F, -16'sh0F0F, 16'sh00FF);
        wait_for_results();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            send_word(rand_coef(), rand_coef(), rand_coef());
    endtask

    // The receiver holds off while words keep coming, so every stage fills and
    // o_ready must fall; afterwards the sender waits for the pipeline to empty.
    task automatic test_full_pipeline_stall();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (n = 0; n < 60; n++)
            send_word(rand_coef(), rand_coef(), rand_coef());
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Input words are predicted before results are checked, so ordering within
    // one edge never matters.
    always @(posedge i_clk) begin
        t_rgb_word want;
        if (i_rst_n && i_valid && o_ready)
            rgb_expected_q.push_back(predict_rgb(i_coef_red, i_coef_green, i_coef_blue));
        if (i_rst_n && o_valid && i_ready) begin
            words_checked++;
            if (rgb_expected_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %0d %0d %0d",
                         $time, o_red_byte, o_green_byte, o_blue_byte);
                error_count++;
            end else begin
                want = rgb_expected_q.pop_front();
                if (o_red_byte !== want.red) begin
                    $display("%0t: red mismatch, expected %0d, got %0d",
                             $time, want.red, o_red_byte);
                    error_count++;
                end
                if (o_green_byte !== want.green) begin
                    $display("%0t: green mismatch, expected %0d, got %0d",
                             $time, want.green, o_green_byte);
                    error_count++;
                end
                if (o_blue_byte !== want.blue) begin
                    $display("%0t: blue mismatch, expected %0d, got %0d",
                             $time, want.blue, o_blue_byte);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_phase(480, 0, 0);
        test_random_phase(480, 60, 0);
        wait_for_results();
        test_random_phase(480, 0, 60);
        test_full_pipeline_stall();
        test_random_phase(480, 21, 21);
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (rgb_expected_q.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, rgb_expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
